>>> rtl/core/aesm_pkg.sv
// shared types, tables and round functions for the aes block mode engine
`timescale 1ns / 1ps
package aesm_pkg;

  localparam int unsigned KeyBits   = 256;
  localparam int unsigned BlockBits = 128;
  localparam int unsigned RkRows    = 16;
  localparam int unsigned RkAddrW   = $clog2(RkRows);

  localparam logic [3:0] NR_128 = 4'd10;
  localparam logic [3:0] NR_192 = 4'd12;
  localparam logic [3:0] NR_256 = 4'd14;

  typedef enum logic [2:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_KSIZE = 3'd4,
    CFG_MODE  = 3'd5,
    CFG_DIR   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KS_128 = 2'd0,
    KS_192 = 2'd1,
    KS_256 = 2'd2
  } key_size_e;

  typedef enum logic [1:0] {
    MODE_ECB    = 2'd0,
    MODE_CBC    = 2'd1,
    MODE_CFB8   = 2'd2,
    MODE_CFB128 = 2'd3
  } cipher_mode_e;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_LOAD = 1'b1
  } operation_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_INIT,
    ST_ROUND,
    ST_WB
  } aesm_state_e;

  // key schedule request from the control side
  typedef struct packed {
    logic       start;
    logic [1:0] key_size;
  } kexp_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] b);
    return INV_SBOX[b];
  endfunction

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // number of rounds, key size code three runs as 256-bit
  function automatic logic [3:0] num_rounds(input logic [1:0] ks);
    logic [3:0] nr;
    case (ks)
      KS_128:  nr = NR_128;
      KS_192:  nr = NR_192;
      default: nr = NR_256;
    endcase
    return nr;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i]   = col[31-8*i -: 8];
      x2     = xtime(a[i]);
      x4     = xtime(x2);
      x8     = xtime(x4);
      m9[i]  = x8 ^ a[i];
      m11[i] = x8 ^ x2 ^ a[i];
      m13[i] = x8 ^ x4 ^ a[i];
      m14[i] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

endpackage

>>> rtl/core/aesm_round.sv
// one aes round in either direction, shared over all rounds of a block
`timescale 1ns / 1ps
module aesm_round (
  input  logic [aesm_pkg::BlockBits-1:0] state_i,
  input  logic [aesm_pkg::BlockBits-1:0] rk_i,
  input  logic                           fwd_i,
  input  logic                           last_i,
  output logic [aesm_pkg::BlockBits-1:0] state_o
);
  import aesm_pkg::*;

  logic [7:0]  s [16];
  logic [7:0]  te [16];
  logic [7:0]  td [16];
  logic [BlockBits-1:0] enc_sr, dec_ak, enc_mix, dec_mix;

  // byte view, byte 0 in the top bits
  always_comb begin
    for (int n = 0; n < 16; n++) begin
      s[n] = state_i[BlockBits-1-8*n -: 8];
    end
  end

  // sub bytes and shift rows, forward and inverse
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        te[i+4*c]             = sbox(s[i+4*((c+i)%4)]);
        td[i+4*((c+i)%4)]     = inv_sbox(s[i+4*c]);
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 16; n++) begin
      enc_sr[BlockBits-1-8*n -: 8] = te[n];
      dec_ak[BlockBits-1-8*n -: 8] = td[n] ^ rk_i[BlockBits-1-8*n -: 8];
    end
  end

  // column mixing
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      enc_mix[BlockBits-1-32*c -: 32] = mix_col(enc_sr[BlockBits-1-32*c -: 32]);
      dec_mix[BlockBits-1-32*c -: 32] = inv_mix_col(dec_ak[BlockBits-1-32*c -: 32]);
    end
  end

  // round result, no column mixing in the final round
  always_comb begin
    if (fwd_i) begin
      state_o = (last_i ? enc_sr : enc_mix) ^ rk_i;
    end else begin
      state_o = last_i ? dec_ak : dec_mix;
    end
  end

endmodule

>>> rtl/core/aesm_keys.sv
// key expansion sequencer and round key memory
`timescale 1ns / 1ps
module aesm_keys (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aesm_pkg::kexp_req_t             req_i,
  input  logic [aesm_pkg::KeyBits-1:0]    key_i,
  input  logic [aesm_pkg::RkAddrW-1:0]    rd_addr_i,
  output logic [aesm_pkg::BlockBits-1:0]  rk_o,
  output logic                            busy_o
);
  import aesm_pkg::*;

  logic                 busy_q, busy_d;
  logic [5:0]           idx_q, idx_d;
  logic [2:0]           imod_q, imod_d;
  logic [7:0]           rcon_q, rcon_d;
  logic [31:0]          win_q [8];
  logic [95:0]          row_q;
  logic [BlockBits-1:0] mem [RkRows];
  logic [BlockBits-1:0] rk_q;

  logic [2:0]  nk_m1, widx;
  logic [5:0]  last_idx;
  logic [31:0] w_prev, w_back, t, w_new;
  logic        from_key;

  // schedule shape from key size
  always_comb begin
    case (req_i.key_size)
      KS_128: begin
        nk_m1    = 3'd3;
        last_idx = 6'd43;
      end
      KS_192: begin
        nk_m1    = 3'd5;
        last_idx = 6'd51;
      end
      default: begin
        nk_m1    = 3'd7;
        last_idx = 6'd59;
      end
    endcase
  end

  // next schedule word
  always_comb begin
    widx     = 3'd7 - idx_q[2:0];
    from_key = idx_q <= {3'b000, nk_m1};
    w_prev   = win_q[0];
    case (nk_m1)
      3'd3:    w_back = win_q[3];
      3'd5:    w_back = win_q[5];
      default: w_back = win_q[7];
    endcase
    t = w_prev;
    if (imod_q == 3'd0) begin
      t = {sbox(w_prev[23:16]) ^ rcon_q, sbox(w_prev[15:8]),
           sbox(w_prev[7:0]), sbox(w_prev[31:24])};
    end else if (nk_m1 == 3'd7 && imod_q == 3'd4) begin
      t = {sbox(w_prev[31:24]), sbox(w_prev[23:16]),
           sbox(w_prev[15:8]), sbox(w_prev[7:0])};
    end
    w_new = from_key ? key_i[widx*32 +: 32] : (w_back ^ t);
  end

  // sequencer counters
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    imod_d = imod_q;
    rcon_d = rcon_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      imod_d = '0;
      rcon_d = 8'h01;
    end else if (busy_q) begin
      idx_d  = idx_q + 6'd1;
      imod_d = (imod_q == nk_m1) ? 3'd0 : imod_q + 3'd1;
      if (!from_key && imod_q == 3'd0) begin
        rcon_d = xtime(rcon_q);
      end
      if (idx_q == last_idx) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      imod_q <= '0;
      rcon_q <= 8'h01;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      imod_q <= imod_d;
      rcon_q <= rcon_d;
    end
  end

  // word window and row assembly
  always_ff @(posedge clk_i) begin
    if (busy_q && !req_i.start) begin
      win_q[0] <= w_new;
      for (int j = 1; j < 8; j++) begin
        win_q[j] <= win_q[j-1];
      end
      row_q <= {row_q[63:0], w_new};
    end
  end

  // round key memory, one row per round key
  always_ff @(posedge clk_i) begin
    if (busy_q && !req_i.start && idx_q[1:0] == 2'b11) begin
      mem[idx_q[5:2]] <= {row_q, w_new};
    end
    rk_q <= mem[rd_addr_i];
  end

  assign rk_o   = rk_q;
  assign busy_o = busy_q;

endmodule

>>> rtl/core/aes_block_mode_engine_unit.sv
// aes block mode engine top level: registers, chaining and round sequencer
// a data request steps through the fetch, init, round and write-back states, and
// the block takes no new request until it is idle again; the single round unit
// runs one round per cycle; a load request sets the chaining value and stays idle
// reset clears the configuration registers and chaining value, then key expansion
// runs with input stalled, as it also does after each key or key size write
`timescale 1ns / 1ps
module aes_block_mode_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import aesm_pkg::*;

  logic [KeyBits-1:0]   key_q;
  logic [1:0]           ks_q, mode_q;
  logic                 dir_q;
  logic [BlockBits-1:0] chain_q, chain_d;
  logic [BlockBits-1:0] din_q, blk_q, blk_d;
  logic [BlockBits-1:0] res, round_out, rk;
  logic [BlockBits-1:0] out_q;
  logic                 out_valid_q;
  logic [3:0]           cnt_q, cnt_d, nr, kstep;
  logic [RkAddrW-1:0]   rd_addr;
  aesm_state_e          state_q, state_d;
  kexp_req_t            kreq;
  logic                 kbusy, fwd, accept, wb_go, last;
  logic [7:0]           y8, fb8;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      ks_q   <= '0;
      mode_q <= '0;
      dir_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY0:  key_q[255:192] <= cfg_data_i;
        CFG_KEY1:  key_q[191:128] <= cfg_data_i;
        CFG_KEY2:  key_q[127:64]  <= cfg_data_i;
        CFG_KEY3:  key_q[63:0]    <= cfg_data_i;
        CFG_KSIZE: ks_q           <= cfg_data_i[1:0];
        CFG_MODE:  mode_q         <= cfg_data_i[1:0];
        CFG_DIR:   dir_q          <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  assign kreq.start    = cfg_we_i && (cfg_idx_i <= CFG_KSIZE);
  assign kreq.key_size = ks_q;

  aesm_keys u_keys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (kreq),
    .key_i     (key_q),
    .rd_addr_i (rd_addr),
    .rk_o      (rk),
    .busy_o    (kbusy)
  );

  assign nr     = num_rounds(ks_q);
  assign fwd    = dir_q || mode_q[1];
  assign last   = cnt_q == nr;
  assign accept = in_valid_i && !in_stall_o;
  assign wb_go  = !out_valid_q || !out_stall_i;

  aesm_round u_round (
    .state_i (blk_q),
    .rk_i    (rk),
    .fwd_i   (fwd),
    .last_i  (last),
    .state_o (round_out)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && operation_i == OP_DATA) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_INIT;
      ST_INIT:  state_d = ST_ROUND;
      ST_ROUND: if (last) state_d = ST_WB;
      ST_WB:    if (wb_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: round count, key address, block register
  always_comb begin
    cnt_d = cnt_q;
    blk_d = blk_q;
    kstep = (state_q == ST_FETCH) ? 4'd0 : cnt_q + 4'd1;
    rd_addr = fwd ? kstep : nr - kstep;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        case (mode_q)
          MODE_ECB: blk_d = {data_high_i, data_low_i};
          MODE_CBC: blk_d = dir_q ? ({data_high_i, data_low_i} ^ chain_q)
                                  : {data_high_i, data_low_i};
          default:  blk_d = chain_q;
        endcase
      end
      ST_INIT: begin
        blk_d = blk_q ^ rk;
        cnt_d = 4'd1;
      end
      ST_ROUND: begin
        blk_d = round_out;
        cnt_d = cnt_q + 4'd1;
      end
      default: ;
    endcase
  end

  // result and chaining update
  always_comb begin
    y8      = din_q[7:0] ^ blk_q[127:120];
    fb8     = dir_q ? y8 : din_q[7:0];
    res     = blk_q;
    chain_d = chain_q;
    case (mode_q)
      MODE_ECB: res = blk_q;
      MODE_CBC: begin
        res     = dir_q ? blk_q : (blk_q ^ chain_q);
        chain_d = dir_q ? blk_q : din_q;
      end
      MODE_CFB8: begin
        res     = {120'd0, y8};
        chain_d = {chain_q[119:0], fb8};
      end
      default: begin
        res     = din_q ^ blk_q;
        chain_d = dir_q ? (din_q ^ blk_q) : din_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_IDLE && accept && operation_i == OP_LOAD) begin
        chain_q <= {data_high_i, data_low_i};
      end else if (state_q == ST_WB && wb_go) begin
        chain_q <= chain_d;
      end
      if (state_q == ST_WB && wb_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      din_q <= {data_high_i, data_low_i};
    end
    if (state_q != ST_WB) begin
      blk_q <= blk_d;
    end
    if (state_q == ST_WB && wb_go) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE) || kbusy;
  assign out_valid_o = out_valid_q;
  assign out_high_o  = out_q[127:64];
  assign out_low_o   = out_q[63:0];

endmodule

>>> rtl/core/aesm_checker.sv
// port level checks for the aes block mode engine
`timescale 1ns / 1ps
module aesm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        operation_i,
  input logic [63:0] data_high_i,
  input logic [63:0] data_low_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] out_high_o,
  input logic [63:0] out_low_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic [63:0] cfg_data_i
);
  import aesm_pkg::*;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_high_o) && $stable(out_low_o))
    else $error("result payload changed while stalled");

  // a data request keeps the block busy
  a_busy_after_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == OP_DATA |=> in_stall_o)
    else $error("request taken while block busy");

  // key or key size write starts key expansion
  a_busy_after_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i <= CFG_KSIZE) |=> in_stall_o)
    else $error("request taken during key expansion");

endmodule

bind aes_block_mode_engine_unit aesm_checker u_aesm_checker (.*);
